>>> hw/rtl/battery_guard_load_supervisor_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the battery guard load supervisor
// Concurrent assertion wrappers that compile to nothing when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef BATTERY_GUARD_LOAD_SUPERVISOR_CORE_MACROS_SVH
`define BATTERY_GUARD_LOAD_SUPERVISOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is high.
`define BGLS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
// Next-cycle implication, disabled while reset is high.
`define BGLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define BGLS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define BGLS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> hw/rtl/bgls_pkg.sv
// ----------------------------------------------------------------------------
// bgls_pkg
// Types and fixed constants shared by the battery guard load supervisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bgls_pkg;

   // ADC block format: the sum of SAMPLE_COUNT samples of ADC_BITS each.
   localparam int SAMPLE_COUNT = 64;
   localparam int ADC_BITS     = 10;
   localparam int SAMPLE_SHIFT = $clog2(SAMPLE_COUNT);

   // Field widths.
   localparam int ADC_SUM_W = 16;
   localparam int HOLD_W    = 6;
   localparam int MV_W      = 14;
   localparam int GAIN_W    = 14;
   localparam int WAKE_W    = 8;
   localparam int DAYS_W    = 8;
   localparam int CPD_W     = 16;
   localparam int COUNT_W   = 24;
   localparam int AVG_W     = ADC_SUM_W - SAMPLE_SHIFT;
   localparam int PROD_W    = AVG_W + GAIN_W;

   // Stream word widths, padded to whole bytes.
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [MV_W-1:0]    MV_MAX    = '1;
   localparam logic [WAKE_W-1:0]  WAKE_MAX  = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Button hold limits in tenths of a second.
   localparam logic [HOLD_W-1:0] HOLD_QUICK   = 6'd10;
   localparam logic [HOLD_W-1:0] HOLD_DISPLAY = 6'd25;
   localparam logic [HOLD_W-1:0] HOLD_MAINT   = 6'd50;

   // Reset values.
   localparam logic [WAKE_W-1:0] WAKE_RESET     = 8'd13;
   localparam logic [MV_W-1:0]   OFF_MV_RESET   = 14'd3300;
   localparam logic [MV_W-1:0]   ON_MV_RESET    = 14'd3600;
   localparam logic [GAIN_W-1:0] GAIN_RESET     = 14'd5010;
   localparam logic [WAKE_W-1:0] INTERVAL_RESET = 8'd13;
   localparam logic [DAYS_W-1:0] DAYS_RESET     = 8'd0;
   localparam logic [CPD_W-1:0]  CPD_RESET      = 16'd2883;

   // Item kinds.
   localparam logic OP_TICK   = 1'b0;
   localparam logic OP_BUTTON = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFF_MV         = 3'd0,
      CSR_ON_MV          = 3'd1,
      CSR_GAIN           = 3'd2,
      CSR_INTERVAL       = 3'd3,
      CSR_REBOOT_DAYS    = 3'd4,
      CSR_CHECKS_PER_DAY = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ACT_NONE         = 3'd0,
      ACT_CHECK        = 3'd1,
      ACT_QUICK_RESET  = 3'd2,
      ACT_DISPLAY      = 3'd3,
      ACT_ENTER_MAINT  = 3'd4,
      ACT_EXIT_MAINT   = 3'd5,
      ACT_TIMED_REBOOT = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      LEVEL_CRITICAL = 2'd0,
      LEVEL_MEDIUM   = 2'd1,
      LEVEL_GOOD     = 2'd2
   } level_type;

endpackage

`default_nettype wire

>>> hw/rtl/battery_guard_load_supervisor_core.sv
// Flow: a word accepted on req is held in the input register, then written to
// the result register once that is free or draining, and shown on rsp there.
// Throughput: one word per cycle unless rsp stalls; with both registers full,
// req_tready follows rsp_tready combinationally. State updates take one stage.
// Reset: synchronous, active high; clears the load, sets the wake count so
// the first tick checks, and restores the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
// battery_guard_load_supervisor_core
// Low-voltage load disconnect with hysteresis, timed reboot and button modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "battery_guard_load_supervisor_core_macros.svh"

module battery_guard_load_supervisor_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request stream
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [15:0] adc_sum, [21:16] hold_tenths, [23:22] zero
   input  wire logic [bgls_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [0] operation
   input  wire logic                                 req_tuser,
   // Response stream
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [0] load_on, [1] reboot_pulse, [15:2] battery_mv, [17:16] battery_level,
   // [18] in_maintenance, [23:19] zero
   output logic [bgls_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   // [2:0] action
   output logic [2:0]                                rsp_tuser,
   // Register write port
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [bgls_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [bgls_pkg::CSR_DATA_W-1:0]      csr_data
);

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [bgls_pkg::MV_W-1:0]   off_mv_ff;
   logic [bgls_pkg::MV_W-1:0]   on_mv_ff;
   logic [bgls_pkg::GAIN_W-1:0] gain_ff;
   logic [bgls_pkg::WAKE_W-1:0] interval_ff;
   logic [bgls_pkg::DAYS_W-1:0] days_ff;
   logic [bgls_pkg::CPD_W-1:0]  cpd_ff;

   assign csr_ready = 1'b1;

   // Register writes; an index beyond the list is accepted and ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         off_mv_ff   <= bgls_pkg::OFF_MV_RESET;
         on_mv_ff    <= bgls_pkg::ON_MV_RESET;
         gain_ff     <= bgls_pkg::GAIN_RESET;
         interval_ff <= bgls_pkg::INTERVAL_RESET;
         days_ff     <= bgls_pkg::DAYS_RESET;
         cpd_ff      <= bgls_pkg::CPD_RESET;
      end else if (csr_valid && csr_ready) begin
         case (bgls_pkg::csr_index_type'(csr_index))
            bgls_pkg::CSR_OFF_MV:         off_mv_ff   <= csr_data[bgls_pkg::MV_W-1:0];
            bgls_pkg::CSR_ON_MV:          on_mv_ff    <= csr_data[bgls_pkg::MV_W-1:0];
            bgls_pkg::CSR_GAIN:           gain_ff     <= csr_data[bgls_pkg::GAIN_W-1:0];
            bgls_pkg::CSR_INTERVAL:       interval_ff <= csr_data[bgls_pkg::WAKE_W-1:0];
            bgls_pkg::CSR_REBOOT_DAYS:    days_ff     <= csr_data[bgls_pkg::DAYS_W-1:0];
            bgls_pkg::CSR_CHECKS_PER_DAY: cpd_ff      <= csr_data[bgls_pkg::CPD_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Handshake: input register feeds the result register
   // ------------------------------------------------------------------------
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic advance;
   logic req_accept;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Input word register.
   logic                           s1_op_ff;
   logic [bgls_pkg::ADC_SUM_W-1:0] s1_sum_ff;
   logic [bgls_pkg::HOLD_W-1:0]    s1_hold_ff;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff   <= req_tuser;
         s1_sum_ff  <= req_tdata[bgls_pkg::ADC_SUM_W-1:0];
         s1_hold_ff <= req_tdata[bgls_pkg::ADC_SUM_W +: bgls_pkg::HOLD_W];
      end
   end

   // ------------------------------------------------------------------------
   // Millivolt conversion and battery level
   // ------------------------------------------------------------------------
   logic [bgls_pkg::AVG_W-1:0]  avg;
   logic [bgls_pkg::PROD_W-1:0] product;
   logic [bgls_pkg::PROD_W-1:0] mv_wide;
   logic [bgls_pkg::MV_W-1:0]   mv;
   logic                        mv_above_off;
   logic                        mv_at_on;
   bgls_pkg::level_type         level;

   assign avg     = s1_sum_ff[bgls_pkg::ADC_SUM_W-1:bgls_pkg::SAMPLE_SHIFT];
   assign product = bgls_pkg::PROD_W'(avg) * bgls_pkg::PROD_W'(gain_ff);
   assign mv_wide = product >> bgls_pkg::ADC_BITS;
   assign mv      = (mv_wide > bgls_pkg::PROD_W'(bgls_pkg::MV_MAX)) ?
                    bgls_pkg::MV_MAX : mv_wide[bgls_pkg::MV_W-1:0];

   assign mv_above_off = mv > off_mv_ff;
   assign mv_at_on     = mv >= on_mv_ff;

   always_comb begin
      if (!mv_above_off) begin
         level = bgls_pkg::LEVEL_CRITICAL;
      end else if (mv <= on_mv_ff) begin
         level = bgls_pkg::LEVEL_MEDIUM;
      end else begin
         level = bgls_pkg::LEVEL_GOOD;
      end
   end

   // ------------------------------------------------------------------------
   // Supervisor state and next-state logic
   // ------------------------------------------------------------------------
   logic                         load_ff,  load_in;
   logic                         maint_ff, maint_in;
   logic [bgls_pkg::WAKE_W-1:0]  wake_ff,  wake_in;
   logic [bgls_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                         pulse;
   bgls_pkg::action_type         action;
   logic [bgls_pkg::COUNT_W-1:0] reboot_target;
   logic [bgls_pkg::WAKE_W-1:0]  wake_after;

   assign reboot_target = bgls_pkg::COUNT_W'(cpd_ff) * bgls_pkg::COUNT_W'(days_ff);

   always_comb begin
      load_in    = load_ff;
      maint_in   = maint_ff;
      wake_in    = wake_ff;
      count_in   = count_ff;
      pulse      = 1'b0;
      action     = bgls_pkg::ACT_NONE;
      wake_after = wake_ff;

      if (maint_ff) begin
         // Only a long hold leaves maintenance; the next tick then checks.
         if (s1_op_ff == bgls_pkg::OP_BUTTON && s1_hold_ff >= bgls_pkg::HOLD_MAINT) begin
            maint_in = 1'b0;
            load_in  = mv_above_off;
            wake_in  = interval_ff;
            count_in = '0;
            action   = bgls_pkg::ACT_EXIT_MAINT;
         end
      end else if (s1_op_ff == bgls_pkg::OP_TICK) begin
         // Battery check with hysteresis, then the optional timed reboot.
         if (wake_ff >= interval_ff) begin
            action     = bgls_pkg::ACT_CHECK;
            wake_after = '0;
            if (!mv_above_off) begin
               load_in = 1'b0;
            end
            if (mv_at_on) begin
               load_in = 1'b1;
            end
            if (days_ff != '0) begin
               if (count_ff != bgls_pkg::COUNT_MAX) begin
                  count_in = count_ff + 1'b1;
               end
               if (count_in >= reboot_target) begin
                  load_in  = mv_above_off;
                  pulse    = mv_above_off;
                  count_in = '0;
                  action   = bgls_pkg::ACT_TIMED_REBOOT;
               end
            end
         end
         wake_in = (wake_after != bgls_pkg::WAKE_MAX) ? wake_after + 1'b1 : wake_after;
      end else begin
         // Button release outside maintenance, decoded by hold time.
         if (s1_hold_ff >= bgls_pkg::HOLD_MAINT) begin
            load_in  = 1'b0;
            maint_in = 1'b1;
            action   = bgls_pkg::ACT_ENTER_MAINT;
         end else if (s1_hold_ff >= bgls_pkg::HOLD_DISPLAY) begin
            action = bgls_pkg::ACT_DISPLAY;
         end else if (s1_hold_ff >= bgls_pkg::HOLD_QUICK) begin
            load_in  = mv_above_off;
            pulse    = mv_above_off;
            wake_in  = '0;
            count_in = '0;
            action   = bgls_pkg::ACT_QUICK_RESET;
         end
      end
   end

   // State moves only when an item leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff  <= 1'b0;
         maint_ff <= 1'b0;
         wake_ff  <= bgls_pkg::WAKE_RESET;
         count_ff <= '0;
      end else if (advance) begin
         load_ff  <= load_in;
         maint_ff <= maint_in;
         wake_ff  <= wake_in;
         count_ff <= count_in;
      end
   end

   // ------------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------------
   logic                      rsp_load_ff;
   logic                      rsp_pulse_ff;
   logic [bgls_pkg::MV_W-1:0] rsp_mv_ff;
   bgls_pkg::level_type       rsp_level_ff;
   logic                      rsp_maint_ff;
   bgls_pkg::action_type      rsp_action_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_load_ff   <= load_in;
         rsp_pulse_ff  <= pulse;
         rsp_mv_ff     <= mv;
         rsp_level_ff  <= level;
         rsp_maint_ff  <= maint_in;
         rsp_action_ff <= action;
      end
   end

   assign rsp_tdata = {5'd0, rsp_maint_ff, rsp_level_ff, rsp_mv_ff, rsp_pulse_ff, rsp_load_ff};
   assign rsp_tuser = rsp_action_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   // Maintenance always holds the load off.
   `BGLS_ASSERT_IMPLIES(a_maint_load_off, clock, reset,
      rsp_valid_ff && rsp_maint_ff, !rsp_load_ff)
   // A reboot pulse only comes from a reset or timed reboot that ended on.
   `BGLS_ASSERT_IMPLIES(a_pulse_source, clock, reset, rsp_valid_ff && rsp_pulse_ff,
      rsp_load_ff && (rsp_action_ff == bgls_pkg::ACT_QUICK_RESET ||
      rsp_action_ff == bgls_pkg::ACT_TIMED_REBOOT))
   // A critical battery never ends a reboot with the load on.
   `BGLS_ASSERT_IMPLIES(a_pulse_level, clock, reset,
      rsp_valid_ff && rsp_level_ff == bgls_pkg::LEVEL_CRITICAL, !rsp_pulse_ff)
   // A held input word is not dropped while the result side is stalled.
   `BGLS_ASSERT_NEXT(a_s1_held, clock, reset, s1_valid_ff && !advance, s1_valid_ff)

endmodule

`default_nettype wire

>>> tb/sv/battery_guard_load_supervisor_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery guard load supervisor testbench
// Drives wake ticks and button releases with summed ADC blocks into the core,
// predicts each status word from its own copy of the supervisor state and
// compares every returned word field by field, under changing register
// settings and with random idling on both stream sides.
// ----------------------------------------------------------------------------

module battery_guard_load_supervisor_core_test;

   localparam int STALL_LIMIT  = 2000;
   localparam int MAX_PRINTED  = 40;

   // One status word as the core returns it.
   typedef struct {
      logic                      load_on;
      logic                      reboot_pulse;
      logic [bgls_pkg::MV_W-1:0] battery_mv;
      bgls_pkg::level_type       level;
      logic                      in_maint;
      bgls_pkg::action_type      action;
   } status_word_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [bgls_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic                             req_tuser = bgls_pkg::OP_TICK;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [bgls_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [2:0]                       rsp_tuser;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [bgls_pkg::CSR_IDX_W-1:0]   csr_index = bgls_pkg::CSR_OFF_MV;
   logic [bgls_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   // Idling percentages for the sender and the receiver.
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int mismatch_count = 0;

   // Status words still to come back, oldest first.
   status_word_type predicted_status[$];

   // Register copies for prediction.
   logic [bgls_pkg::MV_W-1:0]   off_mv       = bgls_pkg::OFF_MV_RESET;
   logic [bgls_pkg::MV_W-1:0]   on_mv        = bgls_pkg::ON_MV_RESET;
   logic [bgls_pkg::GAIN_W-1:0] gain_reg     = bgls_pkg::GAIN_RESET;
   logic [bgls_pkg::WAKE_W-1:0] interval_reg = bgls_pkg::INTERVAL_RESET;
   logic [bgls_pkg::DAYS_W-1:0] days_reg     = bgls_pkg::DAYS_RESET;
   logic [bgls_pkg::CPD_W-1:0]  cpd_reg      = bgls_pkg::CPD_RESET;

   // Supervisor state copies for prediction.
   logic                         load_now   = 1'b0;
   logic [bgls_pkg::WAKE_W-1:0]  wake_now   = bgls_pkg::WAKE_RESET;
   logic [bgls_pkg::COUNT_W-1:0] checks_now = '0;
   logic                         maint_now  = 1'b0;

   battery_guard_load_supervisor_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Receiver side: ready is redrawn every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= rsp_stall_pct);
   end

   // Works out the status word for one item and advances the state copies.
   function automatic status_word_type supervise_item(
         input logic op,
         input logic [bgls_pkg::ADC_SUM_W-1:0] sum,
         input logic [bgls_pkg::HOLD_W-1:0] hold);
      status_word_type           s;
      int unsigned               scaled;
      int unsigned               target;
      logic [bgls_pkg::MV_W-1:0] mv;
      scaled = sum / bgls_pkg::SAMPLE_COUNT;
      scaled = scaled * gain_reg;
      scaled = scaled >> bgls_pkg::ADC_BITS;
      mv = (scaled > bgls_pkg::MV_MAX) ? bgls_pkg::MV_MAX : scaled[bgls_pkg::MV_W-1:0];
      s.battery_mv   = mv;
      s.reboot_pulse = 1'b0;
      s.action       = bgls_pkg::ACT_NONE;
      if (mv <= off_mv)
         s.level = bgls_pkg::LEVEL_CRITICAL;
      else if (mv <= on_mv)
         s.level = bgls_pkg::LEVEL_MEDIUM;
      else
         s.level = bgls_pkg::LEVEL_GOOD;

      if (maint_now) begin
         // Only a long hold leaves maintenance; the next tick is forced to check.
         if (op == bgls_pkg::OP_BUTTON && hold >= bgls_pkg::HOLD_MAINT) begin
            maint_now  = 1'b0;
            load_now   = (mv > off_mv);
            wake_now   = interval_reg;
            checks_now = '0;
            s.action   = bgls_pkg::ACT_EXIT_MAINT;
         end
      end else if (op == bgls_pkg::OP_TICK) begin
         if (wake_now >= interval_reg) begin
            s.action = bgls_pkg::ACT_CHECK;
            if (mv <= off_mv)
               load_now = 1'b0;
            if (mv >= on_mv)
               load_now = 1'b1;
            wake_now = '0;
            // Timed reboot once enough checks make up the configured days.
            if (days_reg != 0) begin
               target = cpd_reg;
               target = target * days_reg;
               if (checks_now != bgls_pkg::COUNT_MAX)
                  checks_now = checks_now + 1'b1;
               if (checks_now >= target) begin
                  load_now       = (mv > off_mv);
                  s.reboot_pulse = load_now;
                  checks_now     = '0;
                  s.action       = bgls_pkg::ACT_TIMED_REBOOT;
               end
            end
         end
         if (wake_now != bgls_pkg::WAKE_MAX)
            wake_now = wake_now + 1'b1;
      end else begin
         if (hold >= bgls_pkg::HOLD_MAINT) begin
            load_now  = 1'b0;
            maint_now = 1'b1;
            s.action  = bgls_pkg::ACT_ENTER_MAINT;
         end else if (hold >= bgls_pkg::HOLD_DISPLAY) begin
            s.action = bgls_pkg::ACT_DISPLAY;
         end else if (hold >= bgls_pkg::HOLD_QUICK) begin
            load_now       = (mv > off_mv);
            s.reboot_pulse = load_now;
            wake_now       = '0;
            checks_now     = '0;
            s.action       = bgls_pkg::ACT_QUICK_RESET;
         end
      end
      s.load_on  = load_now;
      s.in_maint = maint_now;
      return s;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      if (mismatch_count < MAX_PRINTED)
         $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // Compares every returned status word with the oldest prediction.
   always @(posedge clock) begin : check_status
      status_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (predicted_status.size() == 0) begin
            report_mismatch("unexpected status word, action", rsp_tuser, 0);
         end else begin
            want = predicted_status.pop_front();
            if (rsp_tdata[0] !== want.load_on)
               report_mismatch("load_on", rsp_tdata[0], want.load_on);
            if (rsp_tdata[1] !== want.reboot_pulse)
               report_mismatch("reboot_pulse", rsp_tdata[1], want.reboot_pulse);
            if (rsp_tdata[15:2] !== want.battery_mv)
               report_mismatch("battery_mv", rsp_tdata[15:2], want.battery_mv);
            if (rsp_tdata[17:16] !== want.level)
               report_mismatch("battery_level", rsp_tdata[17:16], want.level);
            if (rsp_tdata[18] !== want.in_maint)
               report_mismatch("in_maintenance", rsp_tdata[18], want.in_maint);
            if (rsp_tuser !== want.action)
               report_mismatch("action", rsp_tuser, want.action);
            if (rsp_tdata[23:19] !== 5'd0)
               report_mismatch("padding bits", rsp_tdata[23:19], 0);
         end
      end
   end

   // Ends the run when no word moves on any channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
             || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("** battery_guard_load_supervisor_core: FAILED **");
      $finish;
   end

   // Sends one item, with random gaps before it, and records its prediction.
   task automatic send_item(input logic op, input logic [bgls_pkg::ADC_SUM_W-1:0] sum,
                            input logic [bgls_pkg::HOLD_W-1:0] hold);
      while ($urandom_range(99, 0) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, hold, sum};
      do @(posedge clock); while (!req_tready);
      predicted_status.push_back(supervise_item(op, sum, hold));
   endtask

   // Holds the sender back until every predicted word has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (predicted_status.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input bgls_pkg::csr_index_type idx,
                            input logic [bgls_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         bgls_pkg::CSR_OFF_MV:         off_mv       = value[bgls_pkg::MV_W-1:0];
         bgls_pkg::CSR_ON_MV:          on_mv        = value[bgls_pkg::MV_W-1:0];
         bgls_pkg::CSR_GAIN:           gain_reg     = value[bgls_pkg::GAIN_W-1:0];
         bgls_pkg::CSR_INTERVAL:       interval_reg = value[bgls_pkg::WAKE_W-1:0];
         bgls_pkg::CSR_REBOOT_DAYS:    days_reg     = value[bgls_pkg::DAYS_W-1:0];
         bgls_pkg::CSR_CHECKS_PER_DAY: cpd_reg      = value[bgls_pkg::CPD_W-1:0];
         default: ;
      endcase
   endtask

   // Writes all six registers once the core has gone quiet.
   task automatic apply_settings(input logic [bgls_pkg::MV_W-1:0] off,
                                 input logic [bgls_pkg::MV_W-1:0] on,
                                 input logic [bgls_pkg::GAIN_W-1:0] gain,
                                 input logic [bgls_pkg::WAKE_W-1:0] interval,
                                 input logic [bgls_pkg::DAYS_W-1:0] days,
                                 input logic [bgls_pkg::CPD_W-1:0] cpd);
      wait_idle();
      write_reg(bgls_pkg::CSR_OFF_MV, bgls_pkg::CSR_DATA_W'(off));
      write_reg(bgls_pkg::CSR_ON_MV, bgls_pkg::CSR_DATA_W'(on));
      write_reg(bgls_pkg::CSR_GAIN, bgls_pkg::CSR_DATA_W'(gain));
      write_reg(bgls_pkg::CSR_INTERVAL, bgls_pkg::CSR_DATA_W'(interval));
      write_reg(bgls_pkg::CSR_REBOOT_DAYS, bgls_pkg::CSR_DATA_W'(days));
      write_reg(bgls_pkg::CSR_CHECKS_PER_DAY, cpd);
      csr_valid <= 1'b0;
   endtask

   // Reset defaults: the first tick checks, then every button hold band below maintenance.
   task automatic test_first_check_and_buttons();
      send_item(bgls_pkg::OP_TICK, 16'hFFFF, 6'd0);
      send_item(bgls_pkg::OP_TICK, 16'h0000, 6'd63);
      send_item(bgls_pkg::OP_BUTTON, 16'hFFFF, 6'd0);
      send_item(bgls_pkg::OP_BUTTON, 16'hFFFF, 6'd9);
      send_item(bgls_pkg::OP_BUTTON, 16'hFFFF, 6'd10);
      send_item(bgls_pkg::OP_BUTTON, 16'h0000, 6'd24);
      send_item(bgls_pkg::OP_BUTTON, 16'hFFFF, 6'd25);
      send_item(bgls_pkg::OP_BUTTON, 16'hFFFF, 6'd49);
   endtask

   // Maintenance entry, items ignored inside it, exit on high and low battery.
   task automatic test_maintenance();
      send_item(bgls_pkg::OP_BUTTON, 16'hFFFF, 6'd50);
      send_item(bgls_pkg::OP_TICK, 16'hFFFF, 6'd0);
      send_item(bgls_pkg::OP_BUTTON, 16'hFFFF, 6'd49);
      send_item(bgls_pkg::OP_BUTTON, 16'hFFFF, 6'd63);
      send_item(bgls_pkg::OP_TICK, 16'h0000, 6'd0);
      send_item(bgls_pkg::OP_BUTTON, 16'hFFFF, 6'd63);
      send_item(bgls_pkg::OP_BUTTON, 16'h0000, 6'd50);
   endtask

   // Unity gain so that millivolts equal the average; hits both thresholds exactly.
   task automatic test_thresholds();
      apply_settings(14'd500, 14'd600, 14'd1024, 8'd1, 8'd0, bgls_pkg::CPD_RESET);
      send_item(bgls_pkg::OP_TICK, 16'(500 * bgls_pkg::SAMPLE_COUNT), 6'd0);
      send_item(bgls_pkg::OP_TICK, 16'(600 * bgls_pkg::SAMPLE_COUNT), 6'd0);
      send_item(bgls_pkg::OP_TICK, 16'(501 * bgls_pkg::SAMPLE_COUNT), 6'd0);
      send_item(bgls_pkg::OP_TICK, 16'(601 * bgls_pkg::SAMPLE_COUNT + 63), 6'd0);
   endtask

   // Zero check interval, a two-check day, then zero checks per day on low battery.
   task automatic test_timed_reboot();
      apply_settings(14'd500, 14'd600, 14'd1024, 8'd0, 8'd1, 16'd2);
      send_item(bgls_pkg::OP_TICK, 16'hFFFF, 6'd0);
      send_item(bgls_pkg::OP_TICK, 16'hFFFF, 6'd0);
      apply_settings(14'd500, 14'd600, 14'd1024, 8'd1, 8'd1, 16'd0);
      send_item(bgls_pkg::OP_TICK, 16'h0000, 6'd0);
   endtask

   task automatic test_gain_extremes();
      apply_settings(bgls_pkg::OFF_MV_RESET, bgls_pkg::ON_MV_RESET, 14'd0, 8'd1, 8'd0,
                     bgls_pkg::CPD_RESET);
      send_item(bgls_pkg::OP_TICK, 16'hFFFF, 6'd0);
      apply_settings(bgls_pkg::OFF_MV_RESET, bgls_pkg::ON_MV_RESET, 14'h3FFF, 8'd1, 8'd0,
                     bgls_pkg::CPD_RESET);
      send_item(bgls_pkg::OP_TICK, 16'hFFFF, 6'd0);
   endtask

   // One segment of random items under one register setting.
   task automatic test_random_traffic(input int seg, input int count);
      logic [bgls_pkg::MV_W-1:0]      off, on, swap;
      logic [bgls_pkg::GAIN_W-1:0]    gain;
      logic [bgls_pkg::WAKE_W-1:0]    interval;
      logic [bgls_pkg::DAYS_W-1:0]    days;
      logic [bgls_pkg::CPD_W-1:0]     cpd;
      logic                           op;
      logic [bgls_pkg::ADC_SUM_W-1:0] sum;
      logic [bgls_pkg::HOLD_W-1:0]    hold;
      int                             avg;
      int                             thr;
      case (seg)
         0: begin
            off = bgls_pkg::OFF_MV_RESET; on = bgls_pkg::ON_MV_RESET;
            gain = bgls_pkg::GAIN_RESET; interval = bgls_pkg::INTERVAL_RESET;
            days = bgls_pkg::DAYS_RESET; cpd = bgls_pkg::CPD_RESET;
         end
         1: begin
            off = 14'd0; on = 14'h3FFF; gain = 14'h3FFF;
            interval = 8'hFF; days = 8'hFF; cpd = 16'hFFFF;
         end
         2: begin
            off = 14'h3FFF; on = 14'd0; gain = 14'd0;
            interval = 8'd0; days = 8'd1; cpd = 16'd0;
         end
         default: begin
            gain = bgls_pkg::GAIN_W'($urandom_range(16383, 600));
            off  = bgls_pkg::MV_W'($urandom_range(gain, 0));
            thr  = int'(off) + int'($urandom_range(800, 0));
            on   = (thr > 16383) ? 14'h3FFF : bgls_pkg::MV_W'(thr);
            if ($urandom_range(3, 0) == 0) begin
               swap = off; off = on; on = swap;
            end
            interval = bgls_pkg::WAKE_W'($urandom_range(4, 0));
            days     = bgls_pkg::DAYS_W'($urandom_range(3, 0));
            cpd      = bgls_pkg::CPD_W'($urandom_range(6, 0));
         end
      endcase
      apply_settings(off, on, gain, interval, days, cpd);

      for (int i = 0; i < count; i++) begin
         // Once per segment the sender waits for the core to drain.
         if (i == count / 2)
            wait_idle();
         op = ($urandom_range(99, 0) < 70) ? bgls_pkg::OP_TICK : bgls_pkg::OP_BUTTON;
         case ($urandom_range(4, 0))
            0: hold = bgls_pkg::HOLD_W'($urandom_range(9, 0));
            1: hold = bgls_pkg::HOLD_W'($urandom_range(24, 10));
            2: hold = bgls_pkg::HOLD_W'($urandom_range(49, 25));
            3: hold = bgls_pkg::HOLD_W'($urandom_range(63, 50));
            default: hold = bgls_pkg::HOLD_W'($urandom);
         endcase
         // Mostly aim the battery level at a threshold, else any sum at all.
         if ($urandom_range(9, 0) < 4 || gain == 0) begin
            sum = bgls_pkg::ADC_SUM_W'($urandom);
         end else begin
            thr = ($urandom_range(1, 0) == 1) ? int'(off) : int'(on);
            avg = (thr * 1024 + int'(gain) - 1) / int'(gain)
                  + int'($urandom_range(2, 0)) - 1;
            if (avg < 0)
               avg = 0;
            if (avg > 1023)
               avg = 1023;
            sum = bgls_pkg::ADC_SUM_W'(avg * bgls_pkg::SAMPLE_COUNT
                                       + int'($urandom_range(63, 0)));
         end
         send_item(op, sum, hold);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_first_check_and_buttons();
      test_maintenance();
      test_thresholds();
      test_timed_reboot();
      test_gain_extremes();

      // Random traffic under three idling regimes, three settings each.
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin req_gap_pct = 18; rsp_stall_pct = 72; end
            1: begin req_gap_pct = 72; rsp_stall_pct = 18; end
            default: begin req_gap_pct = 0; rsp_stall_pct = 0; end
         endcase
         for (int k = 0; k < 3; k++)
            test_random_traffic(3 * p + k, 195);
      end

      wait_idle();
      repeat (8) @(posedge clock);
      if (predicted_status.size() != 0)
         report_mismatch("outstanding status words", 0, predicted_status.size());
      if (mismatch_count == 0)
         $display("** battery_guard_load_supervisor_core: PASSED **");
      else
         $display("** battery_guard_load_supervisor_core: FAILED **");
      $finish;
   end

endmodule
